[hw/rtl/ordered_list_delete_ops_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core
// Clocked on clk and disabled during rst of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_DELETE_OPS_CORE_MACROS_SVH
`define ORDERED_LIST_DELETE_OPS_CORE_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define OLIST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ordered list core: property violated");
// condition must never be true out of reset
`define OLIST_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ordered list core: forbidden condition seen");
`else
`define OLIST_ASSERT(label, prop)
`define OLIST_NEVER(label, cond)
`endif

`endif

[hw/rtl/olist_pkg.sv]
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, codes and types of the ordered list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

  // list capacity and derived widths
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // stream widths
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;

  // operation codes
  localparam logic [2:0] FN_APPEND     = 3'd0;
  localparam logic [2:0] FN_DEL_FIRST  = 3'd1;
  localparam logic [2:0] FN_DEL_LAST   = 3'd2;
  localparam logic [2:0] FN_DEL_AFTER  = 3'd3;
  localparam logic [2:0] FN_DEL_BEFORE = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_SHORT    = 3'd3,
    ST_FULL     = 3'd4
  } olist_status_t;

  typedef struct packed {
    logic signed [31:0] search_key;
    logic signed [31:0] new_value;
    logic [2:0]         func;
  } olist_req_t;

  typedef struct packed {
    olist_status_t      status;
    logic signed [31:0] removed_value;
    logic [4:0]         count_after;
  } olist_res_t;

  // low five bits of an entry count, zero extended when the count is narrower
  function automatic logic [4:0] cnt_to_out(input logic [CW-1:0] c);
    logic [CW+4:0] w;
    w = {5'b0, c};
    return w[4:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/olist_ram.sv]
// ----------------------------------------------------------------------------
// olist_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olist_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = $clog2(DEPTH_P)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW_P-1:0]    wr_addr,
  input  wire logic [WIDTH_P-1:0] wr_data,
  input  wire logic [AW_P-1:0]    rd_addr,
  output logic      [WIDTH_P-1:0] rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port with registered data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/olist_seq.sv]
// ----------------------------------------------------------------------------
// olist_seq
// Operation sequencer: appends entries, searches the entry memory for a key and closes the
// gap of a removed entry by moving later entries down one place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_delete_ops_core_macros.svh"

module olist_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire olist_pkg::olist_req_t req,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output olist_pkg::olist_res_t    res
);

  import olist_pkg::*;

  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE       = CW'(1);
  localparam logic [CW-1:0] TWO       = CW'(2);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_RM   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] ra_q, ra_next;
  logic          vld_q, vld_next;
  logic [31:0]   removed, removed_next;
  olist_status_t status, status_next;
  logic [2:0]    func_q;
  logic [31:0]   key_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   rd_data;
  logic          hit;
  logic [CW-1:0] ra_inc;

  olist_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (32)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign hit    = vld_q && (rd_data == key_q);
  assign ra_inc = ra_q + ONE;

  // next state, memory access and result bookkeeping
  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    pos_next     = pos;
    ra_next      = ra_q;
    vld_next     = 1'b0;
    removed_next = removed;
    status_next  = status;
    wr_en        = 1'b0;
    wr_addr      = count[AW-1:0];
    wr_data      = req.new_value;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          status_next  = ST_OK;
          removed_next = '0;
          idx_next     = '0;
          state_next   = S_DONE;
          case (req.func)
            FN_APPEND: begin
              if (count == DEPTH_CNT) begin
                status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + ONE;
              end
            end
            FN_DEL_FIRST: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                pos_next   = '0;
                state_next = S_RM;
              end
            end
            FN_DEL_LAST: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                pos_next   = count - ONE;
                idx_next   = count - ONE;
                state_next = S_RM;
              end
            end
            FN_DEL_AFTER: begin
              state_next = S_SRCH;
            end
            FN_DEL_BEFORE: begin
              if (count < TWO) begin
                status_next = ST_SHORT;
              end else begin
                idx_next   = ONE;
                state_next = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // stream reads through the list and compare returning data to the key
      S_SRCH: begin
        if (hit) begin
          if (func_q == FN_DEL_AFTER) begin
            if (ra_inc >= count) begin
              status_next = ST_NOTFOUND;
              state_next  = S_DONE;
            end else begin
              pos_next   = ra_inc;
              idx_next   = ra_inc;
              state_next = S_RM;
            end
          end else begin
            pos_next   = ra_q - ONE;
            idx_next   = ra_q - ONE;
            state_next = S_RM;
          end
        end else if (idx < count) begin
          vld_next = 1'b1;
          ra_next  = idx;
          idx_next = idx + ONE;
        end else if (!vld_q) begin
          status_next = ST_NOTFOUND;
          state_next  = S_DONE;
        end
      end
      // capture the removed entry, then move each later entry down one place
      S_RM: begin
        if (vld_q) begin
          if (ra_q == pos) begin
            removed_next = rd_data;
          end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(ra_q - ONE);
            wr_data = rd_data;
          end
        end
        if (idx < count) begin
          vld_next = 1'b1;
          ra_next  = idx;
          idx_next = idx + ONE;
        end else if (!vld_q) begin
          count_next = count - ONE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      vld_q <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      vld_q <= vld_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pos     <= pos_next;
    ra_q    <= ra_next;
    removed <= removed_next;
    status  <= status_next;
    if (req_valid && req_ready) begin
      func_q <= req.func;
      key_q  <= req.search_key;
    end
  end

  assign req_ready         = (state == S_IDLE);
  assign res_valid         = (state == S_DONE);
  assign res.status        = status;
  assign res.removed_value = removed;
  assign res.count_after   = cnt_to_out(count);

  `OLIST_NEVER(a_count_max, count > DEPTH_CNT)
  `OLIST_ASSERT(a_rm_addr, (state == S_RM) && vld_q |-> ra_q < count)
  `OLIST_ASSERT(a_count_chg, !$past(rst) && (count != $past(count)) |->
                ($past(state) == S_IDLE) || ($past(state) == S_RM))

endmodule

`default_nettype wire

[hw/rtl/ordered_list_delete_ops_core.sv]
// Sequence: append, delete first/last on an empty list, a short delete-before and unused
// codes go from idle straight to the done state and then into the output register; a
// search or delete runs a search pass that stops at the match and a shift pass from
// the match to the tail over the single entry-memory read port.
// Requests: one at a time, taken the cycle after the result moves into the output register.
// Reset: synchronous rst empties the list and clears the output valid.
// ----------------------------------------------------------------------------
// ordered_list_delete_ops_core
// Ordered list of signed values with append and four delete operations,
// on slave and master stream ports with a registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_delete_ops_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] new_value, [63:32] search_key
  input  wire logic [olist_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] func
  input  wire logic [2:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] removed_value, [36:32] count_after, [39:37] zero
  output logic      [olist_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic      [2:0]                      m_axis_tuser
);

  import olist_pkg::*;

  olist_req_t req;
  olist_res_t res;
  olist_res_t out_q;
  logic       res_valid;
  logic       res_ready;

  assign req.func       = s_axis_tuser;
  assign req.new_value  = s_axis_tdata[31:0];
  assign req.search_key = s_axis_tdata[63:32];

  olist_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output stage takes a result when empty or while its own result drains
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // hold the result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_q.count_after, out_q.removed_value};
  assign m_axis_tuser = out_q.status;

endmodule

`default_nettype wire
